### hdl/jfb_pkg.sv
// Shared types and constants of the frame jitter buffer.
package jfb_pkg;

  localparam int FrameW   = 31;
  localparam int DataW    = 64;
  localparam int CountW   = 6;
  localparam int CommandW = 3;
  localparam int StatusW  = 2;

  localparam logic [CommandW-1:0] CMD_INSERT       = 3'd0;
  localparam logic [CommandW-1:0] CMD_READ_EXACT   = 3'd1;
  localparam logic [CommandW-1:0] CMD_READ_LATEST  = 3'd2;
  localparam logic [CommandW-1:0] CMD_READ_DELAYED = 3'd3;
  localparam logic [CommandW-1:0] CMD_CLEAR        = 3'd4;

  localparam logic [StatusW-1:0] STATUS_OK   = 2'd0;
  localparam logic [StatusW-1:0] STATUS_MISS = 2'd1;
  localparam logic [StatusW-1:0] STATUS_OLD  = 2'd2;

  typedef struct packed {
    logic [CommandW-1:0] command;
    logic [FrameW-1:0]   frame_number;
    logic [DataW-1:0]    payload;
    logic [FrameW-1:0]   delay;
  } request_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [FrameW-1:0]  result_frame;
    logic [DataW-1:0]   result_payload;
    logic [CountW-1:0]  filled_count;
    logic [CountW-1:0]  window_size;
    logic [FrameW-1:0]  oldest_frame;
    logic [FrameW-1:0]  newest_frame;
    logic               buffer_empty;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_PREP,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

### hdl/jfb_cell.sv
// One storage slot of the slot ring: valid mark, frame number and descriptor.
module jfb_cell
  import jfb_pkg::*;
#(
  parameter int PayloadW = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic                valid_in,
  input  logic [FrameW-1:0]   frame_in,
  input  logic [PayloadW-1:0] payload_in,
  output logic                valid,
  output logic [FrameW-1:0]   frame,
  output logic [PayloadW-1:0] payload
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      frame   <= frame_in;
      payload <= payload_in;
    end
  end

endmodule

### hdl/jfb_rem.sv
// Remainder of a frame number by the slot count, by reciprocal multiplication.
module jfb_rem
  import jfb_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [FrameW-1:0]           value,
  output logic [$clog2(CAPACITY)-1:0] rem,
  output logic                        done
);

  localparam int SlotW  = $clog2(CAPACITY);
  localparam int ShiftW = FrameW + SlotW;
  localparam int RecipW = FrameW + 2;
  localparam int ProdW  = FrameW + RecipW;
  // rounded-up reciprocal: the product shifted down by ShiftW is the exact
  // quotient for every frame number, since CAPACITY <= 2**SlotW
  localparam longint RecipL = ((longint'(1) << ShiftW) + longint'(CAPACITY) - longint'(1))
                              / longint'(CAPACITY);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);

  logic [FrameW-1:0] val;
  logic [ProdW-1:0]  prod;
  logic [SlotW-1:0]  quo;
  logic [SlotW-1:0]  back;
  logic              held;
  logic              mult;

  // only the low bits of quotient times divisor matter for the remainder
  always_comb begin
    quo  = SlotW'(prod >> ShiftW);
    back = SlotW'(quo * SlotW'(CAPACITY));
  end

  assign done = mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      mult <= 1'b0;
    end else begin
      held <= load;
      mult <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val <= value;
    end
    if (held) begin
      prod <= ProdW'(val) * ProdW'(Recip);
    end
    if (mult) begin
      rem <= val[SlotW-1:0] - back;
    end
  end

endmodule

### hdl/frame_jitter_buffer.sv
// Top level: sliding-window frame store built as a rotating ring of slots.
//
//   channel   ports                      handshake
//   request   start, busy, request       taken when start=1 and busy=0
//   result    done, result               one-cycle strobe, always taken
//
// Each request makes the slot ring rotate once past a single head unit;
// an insert first waits for its slot index from the reciprocal remainder unit.
// busy stays high from the accepting edge until the result strobe.
// Reset empties the window and clears every valid mark at once.
// The result is registered in the done state and goes out with the strobe;
// the receiver cannot hold it off.
module frame_jitter_buffer
  import jfb_pkg::*;
#(
  parameter int CAPACITY     = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  localparam int SlotW = $clog2(CAPACITY);
  localparam int PW    = PAYLOAD_BITS;
  localparam logic [FrameW-1:0] CapM1 = FrameW'(CAPACITY - 1);

  state_t state, state_next;

  request_t          req;
  logic [FrameW-1:0] low, high, key, tgt, best;
  logic              empty, ignored, near;
  logic [SlotW-1:0]  idx;
  logic [CountW-1:0] count;
  logic              found;
  logic [FrameW-1:0] found_frame;
  logic [PW-1:0]     found_payload;

  logic [SlotW-1:0]  rem;
  logic              rem_done;
  logic              rem_load;

  logic              cv [CAPACITY];
  logic [FrameW-1:0] cf [CAPACITY];
  logic [PW-1:0]     cp [CAPACITY];

  logic              head_v;
  logic [FrameW-1:0] head_f;
  logic [PW-1:0]     head_p;
  logic [FrameW-1:0] gap;
  logic              take;
  logic              scan_en;

  logic [FrameW-1:0] cand;
  logic [FrameW:0]   diff;
  logic [FrameW-1:0] span;
  logic              below;
  logic [FrameW-1:0] key_next;
  result_t           result_next;

  assign busy     = (state != S_IDLE);
  assign scan_en  = (state == S_SCAN);
  assign rem_load = (state == S_IDLE) && start && (request.command == CMD_INSERT);

  jfb_rem #(.CAPACITY(CAPACITY)) u_rem (
    .clk   (clk),
    .rst   (rst),
    .load  (rem_load),
    .value (request.frame_number),
    .rem   (rem),
    .done  (rem_done)
  );

  // ring: each slot takes its upper neighbor, the last takes the updated head
  for (genvar k = 0; k < CAPACITY; k++) begin : g_ring
    if (k == CAPACITY - 1) begin : g_last
      jfb_cell #(.PayloadW(PW)) u_slot (
        .clk        (clk),
        .rst        (rst),
        .shift      (scan_en),
        .valid_in   (head_v),
        .frame_in   (head_f),
        .payload_in (head_p),
        .valid      (cv[k]),
        .frame      (cf[k]),
        .payload    (cp[k])
      );
    end else begin : g_mid
      jfb_cell #(.PayloadW(PW)) u_slot (
        .clk        (clk),
        .rst        (rst),
        .shift      (scan_en),
        .valid_in   (cv[k+1]),
        .frame_in   (cf[k+1]),
        .payload_in (cp[k+1]),
        .valid      (cv[k]),
        .frame      (cf[k]),
        .payload    (cp[k])
      );
    end
  end

  // head unit: update the slot passing the head, index idx
  always_comb begin
    head_v = cv[0];
    head_f = cf[0];
    head_p = cp[0];
    case (req.command)
      CMD_INSERT: begin
        if (!ignored) begin
          // drop frames that fell below the window
          if (cv[0] && (cf[0] < low)) begin
            head_v = 1'b0;
          end
          if (idx == rem) begin
            head_v = 1'b1;
            head_f = req.frame_number;
            head_p = req.payload[PW-1:0];
          end
        end
      end
      CMD_CLEAR: head_v = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    gap = (cf[0] >= tgt) ? cf[0] - tgt : tgt - cf[0];
    // scan runs in slot order, so a strict compare keeps the lowest slot on a tie
    if (near) begin
      take = cv[0] && (!found || (gap < best));
    end else begin
      take = cv[0] && (cf[0] == key);
    end
  end

  always_comb begin
    cand  = (req.frame_number >= CapM1) ? req.frame_number - CapM1 : '0;
    diff  = {1'b0, high} - {1'b0, req.delay};
    span  = high - low + FrameW'(1);
    below = diff[FrameW] || (diff[FrameW-1:0] < low);
    case (req.command)
      CMD_READ_EXACT:   key_next = req.frame_number;
      CMD_READ_LATEST:  key_next = high;
      // target below the bottom: fall back to the bottom frame
      CMD_READ_DELAYED: key_next = low;
      default:          key_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (request.command == CMD_INSERT) ? S_MOD : S_PREP;
        end
      end
      S_MOD: begin
        if (rem_done) begin
          state_next = S_PREP;
        end
      end
      S_PREP: state_next = S_SCAN;
      S_SCAN: begin
        if (idx == SlotW'(CAPACITY - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low   <= '0;
      high  <= '0;
      empty <= 1'b1;
    end else if (state == S_PREP) begin
      if (req.command == CMD_INSERT) begin
        if (empty) begin
          low   <= req.frame_number;
          high  <= req.frame_number;
          empty <= 1'b0;
        end else if (req.frame_number > high) begin
          high <= req.frame_number;
          if (cand > low) begin
            low <= cand;
          end
        end
      end else if (req.command == CMD_CLEAR) begin
        low   <= '0;
        high  <= '0;
        empty <= 1'b1;
      end
    end
  end

  // request hold, setup and scan accumulation
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req <= request;
    end
    if (state == S_PREP) begin
      idx     <= '0;
      count   <= '0;
      found   <= 1'b0;
      best    <= '0;
      tgt     <= diff[FrameW-1:0];
      ignored <= (req.command == CMD_INSERT) && !empty && (req.frame_number < low);
      near    <= (req.command == CMD_READ_DELAYED) && !below;
      key     <= key_next;
    end
    if (scan_en) begin
      idx <= idx + SlotW'(1);
      if (head_v) begin
        count <= count + CountW'(1);
      end
      if (take) begin
        found         <= 1'b1;
        found_frame   <= cf[0];
        found_payload <= cp[0];
        best          <= gap;
      end
    end
  end

  always_comb begin
    result_next                = '0;
    result_next.filled_count   = empty ? '0 : count;
    result_next.window_size    = empty ? '0 : span[CountW-1:0];
    result_next.oldest_frame   = low;
    result_next.newest_frame   = empty ? '0 : high;
    result_next.buffer_empty   = empty;
    unique case (req.command) inside
      CMD_INSERT: result_next.status = ignored ? STATUS_OLD : STATUS_OK;
      CMD_READ_EXACT, CMD_READ_LATEST, CMD_READ_DELAYED: begin
        if (!empty && found) begin
          result_next.result_frame   = found_frame;
          result_next.result_payload = DataW'(found_payload);
        end else begin
          result_next.status = STATUS_MISS;
        end
      end
      default: result_next.status = STATUS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      result <= result_next;
    end
  end

endmodule

### bench/testbench.sv
// Self-checking testbench for the frame jitter buffer: directed and random request streams with a state predictor.
module testbench;
  import jfb_pkg::*;

  localparam int CAPACITY        = 32;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int DRAIN_CYCLES    = 2 * CAPACITY + 40;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PRINT_LIMIT     = 40;
  localparam longint FrameMax    = (64'd1 << FrameW) - 1;

  // encodings outside the defined command set
  localparam logic [CommandW-1:0] CMD_UNUSED_LOW  = 3'd5;
  localparam logic [CommandW-1:0] CMD_UNUSED_HIGH = 3'd7;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  request_t request = '0;
  logic     done;
  result_t  result;

  frame_jitter_buffer #(
    .CAPACITY    (CAPACITY),
    .PAYLOAD_BITS(DataW)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted buffer contents
  bit              ring_valid   [CAPACITY] = '{default: 1'b0};
  logic [FrameW-1:0] ring_frame [CAPACITY] = '{default: '0};
  logic [DataW-1:0]  ring_payload [CAPACITY] = '{default: '0};
  logic [FrameW-1:0] win_low   = '0;
  logic [FrameW-1:0] win_high  = '0;
  bit                win_empty = 1'b1;

  request_t pending_requests[$];
  result_t  expected_results[$];
  int       total_requests;
  int       launched_requests;
  int       accepted_requests;
  int       mismatches;
  int       cycle_count;
  logic     launch_taken;

  function automatic bit find_frame(input logic [FrameW-1:0] f, output logic [DataW-1:0] data);
    int s;
    s = int'(f % CAPACITY);
    data = '0;
    if (win_empty || f < win_low || f > win_high) return 1'b0;
    if (!ring_valid[s] || ring_frame[s] != f) return 1'b0;
    data = ring_payload[s];
    return 1'b1;
  endfunction

  function automatic result_t predict_result(request_t rq);
    result_t           res;
    longint            floor_low;
    longint            step;
    longint            target;
    longint            best;
    longint            gap;
    bit                have;
    logic [FrameW-1:0] pick;
    logic [DataW-1:0]  data;
    int                s;
    int                filled;
    res = '0;
    res.status = STATUS_OK;
    data = '0;
    case (rq.command)
      CMD_INSERT: begin
        if (win_empty) begin
          win_low = rq.frame_number;
          win_high = rq.frame_number;
          win_empty = 1'b0;
        end else if (rq.frame_number > win_high) begin
          floor_low = longint'(rq.frame_number) - CAPACITY + 1;
          if (floor_low < 0) floor_low = 0;
          win_high = rq.frame_number;
          if (floor_low > longint'(win_low)) begin
            // a jump of a whole ring or more drops everything
            if (floor_low - longint'(win_low) >= CAPACITY) begin
              ring_valid = '{default: 1'b0};
            end else begin
              for (step = longint'(win_low); step < floor_low; step++)
                ring_valid[step % CAPACITY] = 1'b0;
            end
            win_low = floor_low[FrameW-1:0];
          end
        end else if (rq.frame_number < win_low) begin
          res.status = STATUS_OLD;
        end
        if (res.status == STATUS_OK) begin
          s = int'(rq.frame_number % CAPACITY);
          ring_valid[s] = 1'b1;
          ring_frame[s] = rq.frame_number;
          ring_payload[s] = rq.payload;
        end
      end
      CMD_READ_EXACT: begin
        if (find_frame(rq.frame_number, data)) res.result_frame = rq.frame_number;
        else res.status = STATUS_MISS;
      end
      CMD_READ_LATEST: begin
        if (!win_empty && find_frame(win_high, data)) res.result_frame = win_high;
        else res.status = STATUS_MISS;
      end
      CMD_READ_DELAYED: begin
        have = 1'b0;
        pick = '0;
        if (!win_empty) begin
          target = longint'(win_high) - longint'(rq.delay);
          if (target < longint'(win_low)) begin
            pick = win_low;
            have = 1'b1;
          end else if (find_frame(target[FrameW-1:0], data)) begin
            pick = target[FrameW-1:0];
            have = 1'b1;
          end else begin
            // nearest stored frame; strict compare keeps the lowest slot on a tie
            best = {1'b0, {63{1'b1}}};
            for (int i = 0; i < CAPACITY; i++) begin
              if (ring_valid[i]) begin
                gap = longint'(ring_frame[i]) - target;
                if (gap < 0) gap = -gap;
                if (gap < best) begin
                  best = gap;
                  pick = ring_frame[i];
                  have = 1'b1;
                end
              end
            end
          end
        end
        if (!win_empty && have && find_frame(pick, data)) res.result_frame = pick;
        else res.status = STATUS_MISS;
      end
      CMD_CLEAR: begin
        ring_valid = '{default: 1'b0};
        win_low = '0;
        win_high = '0;
        win_empty = 1'b1;
      end
      default: ;
    endcase
    res.result_payload = (res.status == STATUS_OK) ? data : '0;
    filled = 0;
    if (!win_empty) begin
      for (int i = 0; i < CAPACITY; i++)
        if (ring_valid[i]) filled++;
    end
    res.filled_count = filled[CountW-1:0];
    res.window_size = win_empty ? '0 : CountW'(win_high - win_low + 1);
    res.oldest_frame = win_low;
    res.newest_frame = win_empty ? '0 : win_high;
    res.buffer_empty = win_empty;
    return res;
  endfunction

  // print the first few mismatches, count them all
  task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %0h expected %0h",
               accepted_requests, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // result monitor and request acceptance
  always @(posedge clk) begin
    if (rst) begin
      launch_taken <= 1'b0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending", result.result_payload, '0);
        end else begin
          result_t want;
          want = expected_results.pop_front();
          check_field("status", DataW'(result.status), DataW'(want.status));
          check_field("result_frame", DataW'(result.result_frame), DataW'(want.result_frame));
          check_field("result_payload", result.result_payload, want.result_payload);
          check_field("filled_count", DataW'(result.filled_count), DataW'(want.filled_count));
          check_field("window_size", DataW'(result.window_size), DataW'(want.window_size));
          check_field("oldest_frame", DataW'(result.oldest_frame), DataW'(want.oldest_frame));
          check_field("newest_frame", DataW'(result.newest_frame), DataW'(want.newest_frame));
          check_field("buffer_empty", DataW'(result.buffer_empty), DataW'(want.buffer_empty));
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_result(request));
        accepted_requests <= accepted_requests + 1;
      end
      launch_taken <= start && !busy;
    end
  end

  // request driver: sender idles 32%, then 78%, then never
  always @(negedge clk) begin
    if (!rst && (!start || launch_taken)) begin
      if (pending_requests.size() != 0 &&
          $urandom_range(99) >= ((launched_requests < total_requests / 3) ? 32 :
                                 (launched_requests < 2 * total_requests / 3) ? 78 : 0)) begin
        request <= pending_requests.pop_front();
        start <= 1'b1;
        launched_requests++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint clamp_frame(longint f);
    if (f < 0) return 0;
    if (f > FrameMax) return FrameMax;
    return f;
  endfunction

  function automatic logic [DataW-1:0] rand_payload();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [FrameW-1:0] rand_frame();
    return FrameW'($urandom());
  endfunction

  task automatic queue_request(logic [CommandW-1:0] cmd, longint frame,
                               logic [DataW-1:0] data, logic [FrameW-1:0] dly);
    request_t rq;
    rq.command = cmd;
    rq.frame_number = frame[FrameW-1:0];
    rq.payload = data;
    rq.delay = dly;
    pending_requests.push_back(rq);
  endtask

  initial begin
    longint top;
    longint frame;
    int     roll;
    int     mode;
    accepted_requests = 0;
    launched_requests = 0;
    mismatches = 0;
    cycle_count = 0;

    // reads on an empty buffer
    queue_request(CMD_READ_LATEST, 0, '1, '1);
    queue_request(CMD_READ_DELAYED, 0, '1, FrameW'(0));
    queue_request(CMD_READ_EXACT, 0, '0, '0);
    // first insert sets the window, then fill and miss
    queue_request(CMD_INSERT, 0, '1, '0);
    queue_request(CMD_INSERT, 5, 64'h0123_4567_89ab_cdef, '1);
    queue_request(CMD_READ_EXACT, 5, '0, '0);
    queue_request(CMD_READ_EXACT, 3, '0, '0);
    queue_request(CMD_READ_LATEST, 0, '0, '0);
    // bottom rises to 9 and evicts 0 and 5
    queue_request(CMD_INSERT, 40, 64'hfedc_ba98_7654_3210, '0);
    queue_request(CMD_INSERT, 3, '1, '0);
    queue_request(CMD_READ_EXACT, 5, '0, '0);
    queue_request(CMD_INSERT, 20, 64'h1111, '0);
    queue_request(CMD_INSERT, 20, 64'h2222, '0);
    queue_request(CMD_READ_DELAYED, 0, '0, FrameW'(0));
    // target 30 missing: 20 and 40 are equally near, slot of 40 is lower
    queue_request(CMD_READ_DELAYED, 0, '0, FrameW'(10));
    // target below the bottom, bottom frame absent then present
    queue_request(CMD_READ_DELAYED, 0, '0, FrameW'(100));
    queue_request(CMD_INSERT, 9, 64'h9999, '0);
    queue_request(CMD_READ_DELAYED, 0, '0, FrameW'(100));
    // jump far ahead to the highest frame number
    queue_request(CMD_INSERT, FrameMax, '0, '0);
    queue_request(CMD_READ_LATEST, 0, '0, '0);
    queue_request(CMD_READ_EXACT, FrameMax, '0, '0);
    queue_request(CMD_READ_DELAYED, 0, '0, '1);
    queue_request(CMD_CLEAR, '1, '1, '1);
    queue_request(CMD_READ_LATEST, 0, '0, '0);
    queue_request(CMD_UNUSED_LOW, 7, '1, '1);
    queue_request(CMD_UNUSED_HIGH, FrameMax, '1, '1);

    // mostly in-order frame streams with reads, some stale, jumps, clears and noise
    top = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        mode = $urandom_range(9);
        if (mode < 6) frame = top + longint'($urandom_range(3));
        else if (mode < 9) frame = top - longint'($urandom_range(40));
        else frame = top + longint'($urandom_range(80, 20));
        frame = clamp_frame(frame);
        if (frame > top) top = frame;
        queue_request(CMD_INSERT, frame, rand_payload(), rand_frame());
      end else if (roll < 60) begin
        queue_request(CMD_READ_EXACT, clamp_frame(top - longint'($urandom_range(36))),
                      rand_payload(), rand_frame());
      end else if (roll < 68) begin
        queue_request(CMD_READ_LATEST, rand_frame(), rand_payload(), rand_frame());
      end else if (roll < 88) begin
        queue_request(CMD_READ_DELAYED, rand_frame(), rand_payload(),
                      ($urandom_range(7) == 0) ? rand_frame() : FrameW'($urandom_range(40)));
      end else if (roll < 90) begin
        queue_request(CMD_CLEAR, rand_frame(), rand_payload(), rand_frame());
        mode = $urandom_range(2);
        if (mode == 0) top = longint'($urandom_range(100));
        else if (mode == 1) top = FrameMax - longint'($urandom_range(300));
        else top = longint'(rand_frame());
      end else begin
        queue_request(CommandW'($urandom_range(4)), rand_frame(), rand_payload(), rand_frame());
      end
    end
    total_requests = pending_requests.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // hold until every request is answered, then watch for stray results
    while (accepted_requests != total_requests || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
